// File: rtl/core/tensor_axis_sum_reduce_core_assert.svh
// Assertion macros for the tensor axis sum reduce core.
// Define ASSERT_OFF to compile the assertions out.
`ifndef TENSOR_AXIS_SUM_REDUCE_CORE_ASSERT_SVH
`define TENSOR_AXIS_SUM_REDUCE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Whenever the condition holds, the consequence holds in the same cycle.
`define TASR_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Whenever the condition holds, the consequence holds in the next cycle.
`define TASR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TASR_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define TASR_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

// File: rtl/core/tasr_pkg.sv
`timescale 1ns / 1ps

package tasr_pkg;

    // Accumulator store
    localparam int INNER_MAX = 1024;
    localparam int SLOT_W    = $clog2(INNER_MAX);

    // Field and register widths
    localparam int CELL_W   = 32;
    localparam int SUM_W    = 48;
    localparam int OUTER_W  = 24;
    localparam int SCNT_W   = 16;
    localparam int INNER_W  = 11;
    localparam int CFG_IX_W = 2;
    localparam int CFG_D_W  = 24;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = OQ_AW + 1;
    localparam int OQ_STALL = OQ_DEPTH - 2;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_OUTER = 2'd0,
        REG_SUM   = 2'd1,
        REG_INNER = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [SUM_W-1:0] sum_value;
        logic             is_final;
    } t_result;

endpackage

// File: rtl/core/tensor_axis_sum_reduce_core.sv
`timescale 1ns / 1ps
`include "tensor_axis_sum_reduce_core_assert.svh"

// Tensor axis sum reduction core.
// Cells of a dense tensor arrive on the cell channel (i_cell_valid / o_cell_stall) in
// row-major order; the tensor is seen as outer x sum x inner. Each cell is added into
// an accumulator slot chosen by its inner position; on the last pass over the summed
// axis the slot total leaves on the result channel (o_res_valid / i_res_stall) with
// o_res_is_final marking the last result of the tensor.
// Registers (outer, sum, inner counts) are written through the cfg channel, which is
// always ready; any write to a known register restarts the position at a new tensor.
// Throughput: one cell per cycle while o_cell_stall is low, set by a single
// read-modify-write of the accumulator RAM per cell. The RAM read is registered at
// acceptance, and the add and write-back happen in the following cycle; a cell hitting
// the slot written in that same cycle takes the sum from a bypass register.
// A result is written from the add stage into the result queue before it is visible.
// Results queue in a four-entry buffer; o_cell_stall rises once two or more results
// wait, so a stalled receiver never causes a result to be lost.
// Reset (synchronous, active low) sets all counts to 1, clears the position and
// empties the pipeline and the queue; the accumulator RAM is not cleared, as the
// first pass over the summed axis loads each slot before it is ever read.
module tensor_axis_sum_reduce_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Cell channel
    input  logic                                 i_cell_valid,
    output logic                                 o_cell_stall,
    input  logic signed [tasr_pkg::CELL_W-1:0]   i_cell_value,
    // Result channel
    output logic                                 o_res_valid,
    input  logic                                 i_res_stall,
    output logic signed [tasr_pkg::SUM_W-1:0]    o_res_sum_value,
    output logic                                 o_res_is_final,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [tasr_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic        [tasr_pkg::CFG_D_W-1:0]  i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tasr_pkg::OUTER_W-1:0] r_outer_count;
    logic [tasr_pkg::SCNT_W-1:0]  r_sum_count;
    logic [tasr_pkg::INNER_W-1:0] r_inner_count;
    logic                         cfg_we;
    logic                         cfg_hit;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        case (tasr_pkg::t_cfg_reg'(i_cfg_index))
            tasr_pkg::REG_OUTER: cfg_hit = 1'b1;
            tasr_pkg::REG_SUM:   cfg_hit = 1'b1;
            tasr_pkg::REG_INNER: cfg_hit = 1'b1;
            default:             cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_count <= tasr_pkg::OUTER_W'(1);
            r_sum_count   <= tasr_pkg::SCNT_W'(1);
            r_inner_count <= tasr_pkg::INNER_W'(1);
        end else if (cfg_we) begin
            case (tasr_pkg::t_cfg_reg'(i_cfg_index))
                tasr_pkg::REG_OUTER: r_outer_count <= i_cfg_data[tasr_pkg::OUTER_W-1:0];
                tasr_pkg::REG_SUM:   r_sum_count   <= i_cfg_data[tasr_pkg::SCNT_W-1:0];
                tasr_pkg::REG_INNER: r_inner_count <= i_cfg_data[tasr_pkg::INNER_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts: zero acts as one, inner saturates at the slot count
    logic [tasr_pkg::OUTER_W-1:0] eff_outer;
    logic [tasr_pkg::SCNT_W-1:0]  eff_sum;
    logic [tasr_pkg::INNER_W-1:0] eff_inner;

    always_comb begin
        eff_outer = (r_outer_count == '0) ? tasr_pkg::OUTER_W'(1) : r_outer_count;
        eff_sum   = (r_sum_count == '0) ? tasr_pkg::SCNT_W'(1) : r_sum_count;
        if (r_inner_count == '0) begin
            eff_inner = tasr_pkg::INNER_W'(1);
        end else if (r_inner_count > tasr_pkg::INNER_W'(tasr_pkg::INNER_MAX)) begin
            eff_inner = tasr_pkg::INNER_W'(tasr_pkg::INNER_MAX);
        end else begin
            eff_inner = r_inner_count;
        end
    end

    // ------------------------------------------------------------------
    // Position counters and per-cell decode
    // ------------------------------------------------------------------
    logic [tasr_pkg::SLOT_W-1:0]  r_inner_index;
    logic [tasr_pkg::SCNT_W-1:0]  r_sum_index;
    logic [tasr_pkg::OUTER_W-1:0] r_outer_index;

    logic                         cell_acc;
    logic [tasr_pkg::SLOT_W-1:0]  slot;
    logic                         last_inner;
    logic                         last_sum;
    logic                         last_outer;

    assign cell_acc = i_cell_valid && !o_cell_stall;

    always_comb begin
        slot = ({1'b0, r_inner_index} < {{(tasr_pkg::INNER_W - tasr_pkg::SLOT_W){1'b0}},
                                         eff_inner[tasr_pkg::SLOT_W-1:0]}
                || eff_inner > tasr_pkg::INNER_W'({tasr_pkg::SLOT_W{1'b1}}))
               ? r_inner_index : '0;
        last_inner = (tasr_pkg::INNER_W'(slot) + tasr_pkg::INNER_W'(1)) >= eff_inner;
        last_sum   = ({1'b0, r_sum_index} + 17'd1) >= {1'b0, eff_sum};
        last_outer = ({1'b0, r_outer_index} + 25'd1) >= {1'b0, eff_outer};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_index <= '0;
            r_sum_index   <= '0;
            r_outer_index <= '0;
        end else if (cfg_we && cfg_hit) begin
            // restart at a new tensor
            r_inner_index <= '0;
            r_sum_index   <= '0;
            r_outer_index <= '0;
        end else if (cell_acc) begin
            if (last_inner) begin
                r_inner_index <= '0;
                if (last_sum) begin
                    r_sum_index   <= '0;
                    r_outer_index <= last_outer ? '0 : r_outer_index + 1'b1;
                end else begin
                    r_sum_index <= r_sum_index + 1'b1;
                end
            end else begin
                r_inner_index <= slot + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Accumulator RAM and the add stage
    // ------------------------------------------------------------------
    logic [tasr_pkg::SUM_W-1:0] r_acc_mem [tasr_pkg::INNER_MAX];
    logic [tasr_pkg::SUM_W-1:0] r_rdata;

    logic                              r_s1_valid;
    logic                              r_s1_first;
    logic                              r_s1_emit;
    logic                              r_s1_final;
    logic                              r_s1_fwd;
    logic [tasr_pkg::SLOT_W-1:0]       r_s1_slot;
    logic signed [tasr_pkg::CELL_W-1:0] r_s1_cell;
    logic [tasr_pkg::SUM_W-1:0]        r_wacc;
    logic [tasr_pkg::SUM_W-1:0]        s1_base;
    logic [tasr_pkg::SUM_W-1:0]        s1_acc;

    // Read the slot as the cell is accepted
    always_ff @(posedge i_clk) begin
        if (cell_acc) begin
            r_rdata <= r_acc_mem[slot];
        end
    end

    // Write back the new total
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_acc_mem[r_s1_slot] <= s1_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= cell_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_acc) begin
            r_s1_first <= (r_sum_index == '0);
            r_s1_emit  <= last_sum;
            r_s1_final <= last_sum && last_outer && last_inner;
            // the slot being written this edge is stale in the RAM read
            r_s1_fwd   <= r_s1_valid && (r_s1_slot == slot);
            r_s1_slot  <= slot;
            r_s1_cell  <= i_cell_value;
        end
        if (r_s1_valid) begin
            r_wacc <= s1_acc;
        end
    end

    always_comb begin
        s1_base = r_s1_fwd ? r_wacc : r_rdata;
        if (r_s1_first) begin
            s1_acc = tasr_pkg::SUM_W'(r_s1_cell);
        end else begin
            s1_acc = s1_base + tasr_pkg::SUM_W'(r_s1_cell);
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    tasr_pkg::t_result          r_oq [tasr_pkg::OQ_DEPTH];
    logic [tasr_pkg::OQ_AW-1:0] r_oq_wr;
    logic [tasr_pkg::OQ_AW-1:0] r_oq_rd;
    logic [tasr_pkg::OQ_CW-1:0] r_oq_count;
    logic                       oq_push;
    logic                       oq_pop;

    assign oq_push = r_s1_valid && r_s1_emit;
    assign oq_pop  = o_res_valid && !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wr] <= '{sum_value: s1_acc, is_final: r_s1_final};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr    <= '0;
            r_oq_rd    <= '0;
            r_oq_count <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            case ({oq_push, oq_pop})
                2'b10:   r_oq_count <= r_oq_count + 1'b1;
                2'b01:   r_oq_count <= r_oq_count - 1'b1;
                default: r_oq_count <= r_oq_count;
            endcase
        end
    end

    // Hold off new cells while two or more results wait; one more may be in flight
    assign o_cell_stall    = (r_oq_count >= tasr_pkg::OQ_CW'(tasr_pkg::OQ_STALL));
    assign o_res_valid     = (r_oq_count != '0);
    assign o_res_sum_value = r_oq[r_oq_rd].sum_value;
    assign o_res_is_final  = r_oq[r_oq_rd].is_final;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TASR_ASSERT_SAME(a_oq_no_overflow, i_clk, i_rst_n, 1'b1,
        r_oq_count <= tasr_pkg::OQ_CW'(tasr_pkg::OQ_DEPTH))
    `TASR_ASSERT_NEXT(a_accept_enters_add, i_clk, i_rst_n, cell_acc, r_s1_valid)
    `TASR_ASSERT_NEXT(a_emit_queues_result, i_clk, i_rst_n, oq_push, r_oq_count != '0)
    `TASR_ASSERT_NEXT(a_same_slot_bypass, i_clk, i_rst_n,
        cell_acc && r_s1_valid && (r_s1_slot == slot), r_s1_fwd)

endmodule

// File: verif/tensor_axis_sum_reduce_core_checker.sv
`timescale 1ns / 1ps

// Watches the cell, result and register channels, predicts each slot total and
// compares every result that leaves the core against the oldest one due.
module tensor_axis_sum_reduce_core_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cell_valid,
    input  logic                                 i_cell_stall,
    input  logic signed [tasr_pkg::CELL_W-1:0]   i_cell_value,
    input  logic                                 i_res_valid,
    input  logic                                 i_res_stall,
    input  logic signed [tasr_pkg::SUM_W-1:0]    i_res_sum_value,
    input  logic                                 i_res_is_final,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic        [tasr_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic        [tasr_pkg::CFG_D_W-1:0]  i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import tasr_pkg::*;

    // Shadow of the core: slot totals, counts and position
    logic [SUM_W-1:0]   slot_total [INNER_MAX];
    logic [OUTER_W-1:0] outer_cnt;
    logic [SCNT_W-1:0]  sum_cnt;
    logic [INNER_W-1:0] inner_cnt;
    logic [SLOT_W-1:0]  inner_pos;
    logic [SCNT_W-1:0]  sum_pos;
    logic [OUTER_W-1:0] outer_pos;

    t_result            sums_due [$];
    t_result            oldest;
    t_result            fresh;
    logic [SUM_W-1:0]   cell_wide;
    int unsigned        span_inner;
    int unsigned        span_sum;
    int unsigned        span_outer;
    int unsigned        slot;
    logic               end_inner;
    logic               end_sum;
    logic               end_outer;
    logic               known_reg;
    int                 mismatches = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            outer_cnt = OUTER_W'(1);
            sum_cnt   = SCNT_W'(1);
            inner_cnt = INNER_W'(1);
            inner_pos = '0;
            sum_pos   = '0;
            outer_pos = '0;
            sums_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (sums_due.size() == 0) begin
                    $error("sum_value: expected no result, got %0d", i_res_sum_value);
                    mismatches++;
                end else begin
                    oldest = sums_due.pop_front();
                    if (oldest.sum_value !== i_res_sum_value) begin
                        $error("sum_value: expected %0d, got %0d",
                               $signed(oldest.sum_value), i_res_sum_value);
                        mismatches++;
                    end
                    if (oldest.is_final !== i_res_is_final) begin
                        $error("is_final: expected %0b, got %0b",
                               oldest.is_final, i_res_is_final);
                        mismatches++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                known_reg = 1'b1;
                case (i_cfg_index)
                    REG_OUTER: outer_cnt = i_cfg_data[OUTER_W-1:0];
                    REG_SUM:   sum_cnt   = i_cfg_data[SCNT_W-1:0];
                    REG_INNER: inner_cnt = i_cfg_data[INNER_W-1:0];
                    default:   known_reg = 1'b0;
                endcase
                // a known register restarts the tensor
                if (known_reg) begin
                    inner_pos = '0;
                    sum_pos   = '0;
                    outer_pos = '0;
                end
            end

            if (i_cell_valid && !i_cell_stall) begin
                // zero counts act as one; inner count clamps at the store depth
                span_inner = (inner_cnt == 0) ? 1 : inner_cnt;
                if (span_inner > INNER_MAX)
                    span_inner = INNER_MAX;
                span_sum   = (sum_cnt == 0) ? 1 : sum_cnt;
                span_outer = (outer_cnt == 0) ? 1 : outer_cnt;
                slot       = (inner_pos < span_inner) ? inner_pos : 0;
                end_inner  = (slot + 1 >= span_inner);
                end_sum    = (int'(sum_pos) + 1 >= span_sum);
                end_outer  = (int'(outer_pos) + 1 >= span_outer);

                cell_wide = {{(SUM_W-CELL_W){i_cell_value[CELL_W-1]}}, i_cell_value};
                // first pass loads the slot, later passes add into it
                if (sum_pos == 0)
                    fresh.sum_value = cell_wide;
                else
                    fresh.sum_value = slot_total[SLOT_W'(slot)] + cell_wide;
                fresh.is_final   = end_outer && end_inner;
                slot_total[SLOT_W'(slot)] = fresh.sum_value;
                if (end_sum)
                    sums_due.push_back(fresh);

                if (end_inner) begin
                    inner_pos = '0;
                    if (end_sum) begin
                        sum_pos   = '0;
                        outer_pos = end_outer ? '0 : outer_pos + 1'b1;
                    end else begin
                        sum_pos = sum_pos + 1'b1;
                    end
                end else begin
                    inner_pos = SLOT_W'(slot + 1);
                end
            end
        end
        o_pending    <= sums_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: verif/tensor_axis_sum_reduce_core_tb.sv
`timescale 1ns / 1ps

// Top of the bench: drives cells, stalls and register writes into the core,
// leaves prediction and comparison to the checker, and gives the verdict.
module tensor_axis_sum_reduce_core_tb;
    import tasr_pkg::*;

    // Index with no register behind it: the core must ignore the write
    localparam logic [CFG_IX_W-1:0]      REG_NONE     = 2'd3;
    localparam logic signed [CELL_W-1:0] CELL_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [CELL_W-1:0] CELL_MIN     = 32'sh8000_0000;
    localparam int                       RANDOM_ITEMS = 650;
    // Settle time after the last result; a cell may still be in the
    // two-stage accumulate path without producing anything
    localparam int                       SETTLE       = 4;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cell_valid;
    logic                        o_cell_stall;
    logic signed [CELL_W-1:0]    i_cell_value;
    logic                        o_res_valid;
    logic                        i_res_stall;
    logic signed [SUM_W-1:0]     o_res_sum_value;
    logic                        o_res_is_final;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic        [CFG_IX_W-1:0]  i_cfg_index;
    logic        [CFG_D_W-1:0]   i_cfg_data;

    int                          fail_count;
    int                          pending;
    int unsigned                 send_pct;
    int unsigned                 stall_pct;

    tensor_axis_sum_reduce_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cell_valid    (i_cell_valid),
        .o_cell_stall    (o_cell_stall),
        .i_cell_value    (i_cell_value),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_res_sum_value (o_res_sum_value),
        .o_res_is_final  (o_res_is_final),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    tensor_axis_sum_reduce_core_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cell_valid    (i_cell_valid),
        .i_cell_stall    (o_cell_stall),
        .i_cell_value    (i_cell_value),
        .i_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .i_res_sum_value (o_res_sum_value),
        .i_res_is_final  (o_res_is_final),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Receiver: stall at the rate of the current idling mode
    always @(posedge i_clk) begin
        i_res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_pct = 0;  stall_pct = 0;  end
            IDLE_SEND: begin send_pct = 79; stall_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  stall_pct = 79; end
            default:   begin send_pct = 30; stall_pct = 30; end
        endcase
    endtask

    // Offer one cell and hold it until the core takes it. Valid stays high
    // into the next item unless a gap is drawn, so it is never dropped and
    // raised in the same step.
    task automatic send_cell(input logic signed [CELL_W-1:0] value);
        while ($urandom_range(99) < send_pct) begin
            i_cell_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cell_valid <= 1'b1;
        i_cell_value <= value;
        do @(posedge i_clk); while (o_cell_stall);
    endtask

    // One register write; drop valid for a cycle afterwards
    task automatic write_reg(input logic [CFG_IX_W-1:0] index, input logic [CFG_D_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending, wait for every due result, then let the pipe settle
    task automatic drain(input int tail);
        i_cell_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic set_shape(input int unsigned outer, input int unsigned sum,
                             input int unsigned inner);
        write_reg(REG_OUTER, CFG_D_W'(outer));
        write_reg(REG_SUM, CFG_D_W'(sum));
        write_reg(REG_INNER, CFG_D_W'(inner));
    endtask

    // Bias towards the extremes so the 48-bit totals get exercised
    function automatic logic signed [CELL_W-1:0] pick_cell();
        case ($urandom_range(7))
            0:       return CELL_MAX;
            1:       return CELL_MIN;
            2:       return CELL_W'($signed(16'($urandom)));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned n_outer;
        int unsigned n_sum;
        int unsigned n_inner;
        int unsigned span;
        int unsigned cells;
        int unsigned random_sent;
        int unsigned phase;
        int unsigned k;

        i_rst_n      <= 1'b0;
        i_cell_valid <= 1'b0;
        i_cell_value <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_OUTER;
        i_cfg_data   <= '0;
        i_res_stall  <= 1'b0;
        set_idling(IDLE_NONE);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset shape is 1x1x1: each cell passes straight through as a final
        send_cell(CELL_MAX);
        send_cell(CELL_MIN);
        send_cell('0);
        send_cell(-1);
        send_cell(1);
        drain(SETTLE);

        // 2x3x2 with saturated cells: totals need more than 32 bits
        set_shape(2, 3, 2);
        repeat (6) send_cell(CELL_MAX);
        repeat (6) send_cell(CELL_MIN);
        drain(SETTLE);

        // Zero in every count register acts as one
        set_shape(0, 0, 0);
        send_cell(pick_cell());
        send_cell(pick_cell());
        drain(SETTLE);

        // Bad index mid-tensor: ignored, so the position must carry on
        set_shape(1, 2, 1);
        send_cell(CELL_MIN);
        drain(SETTLE);
        write_reg(REG_NONE, 24'hFF_FFFF);
        send_cell(CELL_MIN);
        drain(SETTLE);

        // Inner count above the store depth clamps: final lands on cell 1024
        set_shape(1, 1, 2047);
        repeat (1030) send_cell(pick_cell());
        drain(SETTLE);

        // Random phases: mostly whole tensors of small shapes, some cut short,
        // every third phase an extreme shape; idling cycles through its modes
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            set_idling(t_idle_mode'(phase % 4));
            if ($urandom_range(3) == 0)
                write_reg(REG_NONE, CFG_D_W'($urandom));
            if (phase % 3 == 2) begin
                case ((phase / 3) % 5)
                    0: set_shape(24'hFF_FFFF, 2, 3);
                    1: set_shape(1, 16'hFFFF, 1);
                    2: set_shape(0, 0, 0);
                    3: set_shape(0, 1, 1024);
                    default: set_shape(3, 0, 5);
                endcase
                cells = 40;
            end else begin
                n_outer = $urandom_range(1, 3);
                n_sum   = $urandom_range(1, 4);
                n_inner = $urandom_range(1, 6);
                span    = n_outer * n_sum * n_inner;
                cells   = span * $urandom_range(1, 3);
                // leave a tensor unfinished now and then
                if ($urandom_range(3) == 0)
                    cells += $urandom_range(1, span);
                set_shape(n_outer, n_sum, n_inner);
            end
            for (k = 0; k < cells; k++) begin
                // hold off mid-phase until every due result is out
                if (k == cells / 2 && (phase == 2 || $urandom_range(9) == 0))
                    drain(0);
                send_cell(pick_cell());
            end
            random_sent += cells;
            drain(SETTLE);
            phase++;
        end

        drain(2 * SETTLE);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
